@@ hw/rtl/mode_gated_velocity_slew_limiter_core_defines.svh @@
// ----------------------------------------------------------------------------
// Slew limiter assertion macros
// Shared concurrent check forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MODE_GATED_VELOCITY_SLEW_LIMITER_CORE_DEFINES_SVH
`define MODE_GATED_VELOCITY_SLEW_LIMITER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MGVS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slew limiter check failed");

// consequent must hold in the cycle after the antecedent
`define MGVS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slew limiter check failed");

`endif

@@ hw/rtl/mgvs_pkg.sv @@
// ----------------------------------------------------------------------------
// Slew limiter package
// Widths, register indexes, flag codes and shared types.
// ----------------------------------------------------------------------------
package mgvs_pkg;

	localparam int VEL_W      = 16;
	localparam int RATIO_FRAC = 8;
	localparam int RATIO_W    = RATIO_FRAC + 1;
	localparam int STEP_W     = VEL_W - 1;
	localparam int TICK_W     = 16;
	localparam int FLAG_W     = 8;
	localparam int PROD_W     = VEL_W + RATIO_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLOW_GAIN,
		CFG_LINEAR_STEP,
		CFG_ANGULAR_STEP,
		CFG_TIMEOUT_TICKS
	} cfg_idx_t;

	localparam logic [FLAG_W-1:0] FLAG_NORMAL = FLAG_W'(0);
	localparam logic [FLAG_W-1:0] FLAG_RED    = FLAG_W'(1);
	localparam logic [FLAG_W-1:0] FLAG_SLOW   = FLAG_W'(2);
	localparam logic [FLAG_W-1:0] FLAG_PED    = FLAG_W'(3);
	localparam logic [FLAG_W-1:0] FLAG_STOP   = FLAG_W'(4);

	localparam logic [RATIO_W-1:0] SLOW_GAIN_RST    = RATIO_W'(102);
	localparam logic [STEP_W-1:0]  LINEAR_STEP_RST  = STEP_W'(17);
	localparam logic [STEP_W-1:0]  ANGULAR_STEP_RST = STEP_W'(34);
	localparam logic [TICK_W-1:0]  TIMEOUT_RST      = TICK_W'(30);

	typedef struct packed {
		logic [RATIO_W-1:0] slow_gain;
		logic [STEP_W-1:0]  linear_step;
		logic [STEP_W-1:0]  angular_step;
		logic [TICK_W-1:0]  timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] nav_linear;
		logic signed [VEL_W-1:0] nav_angular;
		logic                    flag_new;
		logic [FLAG_W-1:0]       safety_flag;
	} cmd_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] lin;
		logic signed [VEL_W-1:0] ang;
	} target_t;

endpackage

@@ hw/rtl/mgvs_if.sv @@
// ----------------------------------------------------------------------------
// Slew limiter channels
// Command channel and velocity result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mgvs_cmd_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [mgvs_pkg::VEL_W-1:0]       nav_linear;
	logic signed [mgvs_pkg::VEL_W-1:0]       nav_angular;
	logic                                    flag_new;
	logic        [mgvs_pkg::FLAG_W-1:0]      safety_flag;

	modport source (output valid, nav_linear, nav_angular, flag_new, safety_flag,
		input ready);
	modport sink (input valid, nav_linear, nav_angular, flag_new, safety_flag,
		output ready);
endinterface

interface mgvs_vel_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [mgvs_pkg::VEL_W-1:0]       out_linear;
	logic signed [mgvs_pkg::VEL_W-1:0]       out_angular;

	modport source (output valid, out_linear, out_angular, input ready);
	modport sink (input valid, out_linear, out_angular, output ready);
endinterface

@@ hw/rtl/mgvs_mode_target.sv @@
// ----------------------------------------------------------------------------
// Slew limiter mode and target
// Tracks the held safety flag and its age, picks the per-axis target.
// ----------------------------------------------------------------------------
module mgvs_mode_target (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  mgvs_pkg::cmd_t        cmd,
	input  mgvs_pkg::cfg_t        cfg,
	output mgvs_pkg::target_t     target
);

	logic [mgvs_pkg::FLAG_W-1:0] held_q, held_nx, mode;
	logic [mgvs_pkg::TICK_W-1:0] ticks_q, ticks_nx;

	// floor(v * ratio / 2^frac), clamped to the velocity range
	function automatic logic signed [mgvs_pkg::VEL_W-1:0] scale_slow(
		input logic signed [mgvs_pkg::VEL_W-1:0] v,
		input logic [mgvs_pkg::RATIO_W-1:0] ratio
	);
		logic signed [mgvs_pkg::PROD_W-1:0] p;
		logic signed [mgvs_pkg::PROD_W-1:0] sh;
		logic signed [mgvs_pkg::VEL_W-1:0]  r;
		p  = v * $signed({1'b0, ratio});
		sh = p >>> mgvs_pkg::RATIO_FRAC;
		if (sh[mgvs_pkg::PROD_W-1:mgvs_pkg::VEL_W-1] == '0 ||
			sh[mgvs_pkg::PROD_W-1:mgvs_pkg::VEL_W-1] == '1) begin
			r = sh[mgvs_pkg::VEL_W-1:0];
		end else if (sh[mgvs_pkg::PROD_W-1]) begin
			r = {1'b1, {(mgvs_pkg::VEL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(mgvs_pkg::VEL_W-1){1'b1}}};
		end
		return r;
	endfunction

	always_comb begin
		held_nx  = cmd.flag_new ? cmd.safety_flag : held_q;
		if (cmd.flag_new) begin
			ticks_nx = '0;
		end else if (ticks_q == '1) begin
			ticks_nx = ticks_q;
		end else begin
			ticks_nx = ticks_q + mgvs_pkg::TICK_W'(1);
		end
		mode = (ticks_nx > cfg.timeout_ticks) ? mgvs_pkg::FLAG_NORMAL : held_nx;
	end

	always_comb begin
		case (mode)
			mgvs_pkg::FLAG_RED, mgvs_pkg::FLAG_PED, mgvs_pkg::FLAG_STOP: begin
				target.lin = '0;
				target.ang = '0;
			end
			mgvs_pkg::FLAG_SLOW: begin
				target.lin = scale_slow(cmd.nav_linear, cfg.slow_gain);
				target.ang = scale_slow(cmd.nav_angular, cfg.slow_gain);
			end
			default: begin
				// normal and unknown codes pass the command through
				target.lin = cmd.nav_linear;
				target.ang = cmd.nav_angular;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= mgvs_pkg::FLAG_NORMAL;
			ticks_q <= '0;
		end else if (adv) begin
			held_q  <= held_nx;
			ticks_q <= ticks_nx;
		end
	end

endmodule

@@ hw/rtl/mgvs_slew.sv @@
// ----------------------------------------------------------------------------
// Slew limiter axis ramp
// Moves one axis toward its target by at most the given step.
// ----------------------------------------------------------------------------
module mgvs_slew (
	input  logic signed [mgvs_pkg::VEL_W-1:0]  cur,
	input  logic signed [mgvs_pkg::VEL_W-1:0]  target,
	input  logic        [mgvs_pkg::STEP_W-1:0] step,
	output logic signed [mgvs_pkg::VEL_W-1:0]  nxt
);

	logic signed [mgvs_pkg::VEL_W:0] cur_x, diff, stp, moved;
	logic                            near;

	always_comb begin
		cur_x = $signed({cur[mgvs_pkg::VEL_W-1], cur});
		diff  = $signed({target[mgvs_pkg::VEL_W-1], target}) - cur_x;
		stp   = $signed({{(mgvs_pkg::VEL_W+1-mgvs_pkg::STEP_W){1'b0}}, step});
		near  = (diff <= stp) && (diff >= -stp);
		// a far target keeps cur +/- step inside the range
		moved = (diff > 0) ? (cur_x + stp) : (cur_x - stp);
		nxt   = near ? target : moved[mgvs_pkg::VEL_W-1:0];
	end

endmodule

@@ hw/rtl/mode_gated_velocity_slew_limiter_core.sv @@
// ----------------------------------------------------------------------------
// Mode-gated velocity slew limiter
// Safety-flag gated target selection followed by a two-axis slew limit.
//
//  channel | dir | handshake    | payload
//  cmd     | in  | valid/ready  | nav_linear, nav_angular, flag_new, safety_flag
//  vel     | out | valid/ready  | out_linear, out_angular
//
//  One item per cycle sustained while vel.ready is high.
//  Input register, then flag/target stage with the slow-mode multiply, then
//  the slew stage whose result register also holds the running output.
//  Reset clears the flag, tick counter and outputs; registers take defaults.
//  A stalled result holds; empty stages still take items while it waits.
// ----------------------------------------------------------------------------
`include "mode_gated_velocity_slew_limiter_core_defines.svh"

module mode_gated_velocity_slew_limiter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mgvs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mgvs_pkg::CFG_DATA_W-1:0]   cfg_data,
	mgvs_cmd_if.sink                          cmd,
	mgvs_vel_if.source                        vel
);

	mgvs_pkg::cfg_t    cfg_q;
	mgvs_pkg::cmd_t    cmd_s1;
	mgvs_pkg::target_t tgt, tgt_s2;
	logic              s1_v, s2_v, out_v_q;
	logic              s1_rdy, s2_rdy, out_rdy;
	logic              adv_a, adv_b;
	logic signed [mgvs_pkg::VEL_W-1:0] lin_q, ang_q, lin_nx, ang_nx;
	logic signed [mgvs_pkg::VEL_W:0]   lin_move, ang_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_gain     <= mgvs_pkg::SLOW_GAIN_RST;
			cfg_q.linear_step   <= mgvs_pkg::LINEAR_STEP_RST;
			cfg_q.angular_step  <= mgvs_pkg::ANGULAR_STEP_RST;
			cfg_q.timeout_ticks <= mgvs_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (mgvs_pkg::cfg_idx_t'(cfg_index))
				mgvs_pkg::CFG_SLOW_GAIN:
					cfg_q.slow_gain <= cfg_data[mgvs_pkg::RATIO_W-1:0];
				mgvs_pkg::CFG_LINEAR_STEP:
					cfg_q.linear_step <= cfg_data[mgvs_pkg::STEP_W-1:0];
				mgvs_pkg::CFG_ANGULAR_STEP:
					cfg_q.angular_step <= cfg_data[mgvs_pkg::STEP_W-1:0];
				mgvs_pkg::CFG_TIMEOUT_TICKS:
					cfg_q.timeout_ticks <= cfg_data[mgvs_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// each stage takes an item when empty or when its own item moves on
	assign out_rdy   = !out_v_q || vel.ready;
	assign s2_rdy    = !s2_v || out_rdy;
	assign s1_rdy    = !s1_v || s2_rdy;
	assign cmd.ready = s1_rdy;
	assign adv_a     = s1_v && s2_rdy;
	assign adv_b     = s2_v && out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			s2_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_rdy) s1_v <= cmd.valid;
			if (s2_rdy) s2_v <= s1_v;
			if (out_rdy) out_v_q <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && s1_rdy) begin
			cmd_s1.nav_linear  <= cmd.nav_linear;
			cmd_s1.nav_angular <= cmd.nav_angular;
			cmd_s1.flag_new    <= cmd.flag_new;
			cmd_s1.safety_flag <= cmd.safety_flag;
		end
		if (adv_a) tgt_s2 <= tgt;
	end

	mgvs_mode_target u_mode (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv_a),
		.cmd    (cmd_s1),
		.cfg    (cfg_q),
		.target (tgt)
	);

	mgvs_slew u_slew_lin (
		.cur    (lin_q),
		.target (tgt_s2.lin),
		.step   (cfg_q.linear_step),
		.nxt    (lin_nx)
	);

	mgvs_slew u_slew_ang (
		.cur    (ang_q),
		.target (tgt_s2.ang),
		.step   (cfg_q.angular_step),
		.nxt    (ang_nx)
	);

	// result register doubles as the running output of each axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_q <= '0;
			ang_q <= '0;
		end else if (adv_b) begin
			lin_q <= lin_nx;
			ang_q <= ang_nx;
		end
	end

	assign vel.valid       = out_v_q;
	assign vel.out_linear  = lin_q;
	assign vel.out_angular = ang_q;

	assign lin_move = $signed({lin_nx[mgvs_pkg::VEL_W-1], lin_nx})
		- $signed({lin_q[mgvs_pkg::VEL_W-1], lin_q});
	assign ang_move = $signed({ang_nx[mgvs_pkg::VEL_W-1], ang_nx})
		- $signed({ang_q[mgvs_pkg::VEL_W-1], ang_q});

	`MGVS_ASSERT_NEXT(a_s2_to_out, adv_b, vel.valid)
	`MGVS_ASSERT_NEXT(a_cmd_to_s1, cmd.valid && cmd.ready, s1_v)
	`MGVS_ASSERT_NOW(a_empty_s1_ready, !s1_v, cmd.ready)
	`MGVS_ASSERT_NOW(a_lin_bound, adv_b,
		(lin_move <= $signed({2'b00, cfg_q.linear_step}))
		&& (lin_move >= -$signed({2'b00, cfg_q.linear_step})))
	`MGVS_ASSERT_NOW(a_ang_bound, adv_b,
		(ang_move <= $signed({2'b00, cfg_q.angular_step}))
		&& (ang_move >= -$signed({2'b00, cfg_q.angular_step})))

endmodule

@@ verif/tb_mode_gated_velocity_slew_limiter_core.sv @@
// ----------------------------------------------------------------------------
// Slew limiter core testbench
// Drives control ticks with random gaps on both channels and predicts each
// velocity result from a cycle-free model of the flag, timeout and ramp logic.
// A short directed set comes first: field extremes, every flag code, slow-mode
// saturation, timeout, zero step and the longest timeout. Random ticks
// follow under several register settings.
// ----------------------------------------------------------------------------
module tb_mode_gated_velocity_slew_limiter_core;
	import mgvs_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT    = 12;

	typedef struct packed {
		logic signed [VEL_W-1:0] lin;
		logic signed [VEL_W-1:0] ang;
	} vel_pair_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mgvs_cmd_if cmd_ch ();
	mgvs_vel_if vel_ch ();

	mode_gated_velocity_slew_limiter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.vel       (vel_ch)
	);

	// predictor state and register copies
	logic [RATIO_W-1:0]      ratio_q8;
	logic [STEP_W-1:0]       lin_step;
	logic [STEP_W-1:0]       ang_step;
	logic [TICK_W-1:0]       flag_timeout;
	logic [FLAG_W-1:0]       held_flag;
	logic [TICK_W-1:0]       ticks_idle;
	logic signed [VEL_W-1:0] lin_now;
	logic signed [VEL_W-1:0] ang_now;

	vel_pair_t expected_vel_q[$];

	bit steady;
	int n_ticks;
	int n_checked;
	int n_mismatch;
	int n_unexpected;
	int n_settings;
	int stall_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [VEL_W-1:0] slow_scale(logic signed [VEL_W-1:0] v);
		int prod;
		prod = int'(v) * int'(ratio_q8);
		prod = prod >>> RATIO_FRAC;
		if (prod > 32767)
			return 16'sh7FFF;
		if (prod < -32768)
			return 16'sh8000;
		return VEL_W'(prod);
	endfunction

	function automatic logic signed [VEL_W-1:0] ramp(logic signed [VEL_W-1:0] cur,
			logic signed [VEL_W-1:0] goal, logic [STEP_W-1:0] step);
		int diff;
		int s;
		diff = int'(goal) - int'(cur);
		s = int'(step);
		if (diff <= s && diff >= -s)
			return goal;
		return VEL_W'(int'(cur) + (diff > 0 ? s : -s));
	endfunction

	function automatic vel_pair_t predict_tick(cmd_t c);
		logic [FLAG_W-1:0]       mode;
		logic signed [VEL_W-1:0] goal_lin;
		logic signed [VEL_W-1:0] goal_ang;
		vel_pair_t               r;
		if (c.flag_new) begin
			held_flag = c.safety_flag;
			ticks_idle = '0;
		end else if (ticks_idle != '1) begin
			ticks_idle = ticks_idle + 1'b1;
		end
		mode = (ticks_idle > flag_timeout) ? FLAG_NORMAL : held_flag;
		case (mode)
			FLAG_RED, FLAG_PED, FLAG_STOP: begin
				goal_lin = '0;
				goal_ang = '0;
			end
			FLAG_SLOW: begin
				goal_lin = slow_scale(c.nav_linear);
				goal_ang = slow_scale(c.nav_angular);
			end
			default: begin
				goal_lin = c.nav_linear;
				goal_ang = c.nav_angular;
			end
		endcase
		lin_now = ramp(lin_now, goal_lin, lin_step);
		ang_now = ramp(ang_now, goal_ang, ang_step);
		r.lin = lin_now;
		r.ang = ang_now;
		return r;
	endfunction

	// accepted ticks feed the predictor, accepted results are checked in order
	always @(posedge clk) begin
		vel_pair_t want;
		cmd_t      c;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				c.nav_linear = cmd_ch.nav_linear;
				c.nav_angular = cmd_ch.nav_angular;
				c.flag_new = cmd_ch.flag_new;
				c.safety_flag = cmd_ch.safety_flag;
				expected_vel_q.push_back(predict_tick(c));
				n_ticks++;
			end
			if (vel_ch.valid && vel_ch.ready) begin
				if (expected_vel_q.size() == 0) begin
					n_unexpected++;
					$display("result with nothing expected: lin %0d ang %0d",
						vel_ch.out_linear, vel_ch.out_angular);
				end else begin
					want = expected_vel_q.pop_front();
					n_checked++;
					if (vel_ch.out_linear !== want.lin || vel_ch.out_angular !== want.ang) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("mismatch on result %0d: expected lin %0d ang %0d, got lin %0d ang %0d",
								n_checked, want.lin, want.ang,
								vel_ch.out_linear, vel_ch.out_angular);
					end
				end
			end
			if ((cmd_ch.valid && cmd_ch.ready) || (vel_ch.valid && vel_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("no progress for %0d cycles", STALL_LIMIT);
				$display("[mode_gated_velocity_slew_limiter_core] ERROR");
				$finish;
			end
		end
	end

	always @(negedge clk)
		vel_ch.ready = steady || ($urandom_range(99) >= IDLE_PCT);

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_SLOW_GAIN:     ratio_q8 = val[RATIO_W-1:0];
			CFG_LINEAR_STEP:   lin_step = val[STEP_W-1:0];
			CFG_ANGULAR_STEP:  ang_step = val[STEP_W-1:0];
			CFG_TIMEOUT_TICKS: flag_timeout = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input int ratio, input int lstep, input int astep, input int tmo);
		write_reg(CFG_SLOW_GAIN, CFG_DATA_W'(ratio));
		write_reg(CFG_LINEAR_STEP, CFG_DATA_W'(lstep));
		write_reg(CFG_ANGULAR_STEP, CFG_DATA_W'(astep));
		write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(tmo));
		n_settings++;
	endtask

	task automatic issue_tick(input cmd_t c);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.nav_linear = c.nav_linear;
		cmd_ch.nav_angular = c.nav_angular;
		cmd_ch.flag_new = c.flag_new;
		cmd_ch.safety_flag = c.safety_flag;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
	endtask

	// every tick gives a result, so an empty queue means the pipe is empty
	task automatic settle();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (expected_vel_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic cmd_t mk_tick(int lin, int ang, bit fresh, int flag);
		cmd_t c;
		c.nav_linear = VEL_W'(lin);
		c.nav_angular = VEL_W'(ang);
		c.flag_new = fresh;
		c.safety_flag = FLAG_W'(flag);
		return c;
	endfunction

	function automatic logic signed [VEL_W-1:0] random_vel();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					3: return 16'shFFFF;
					default: return 16'sh0001;
				endcase
			end
			1, 2, 3, 4, 5: return VEL_W'(int'($urandom_range(4000)) - 2000);
			default: return VEL_W'($urandom);
		endcase
	endfunction

	function automatic cmd_t random_tick(int new_pct);
		cmd_t c;
		c.nav_linear = random_vel();
		c.nav_angular = random_vel();
		c.flag_new = ($urandom_range(99) < new_pct);
		if ($urandom_range(99) < 85)
			c.safety_flag = FLAG_W'($urandom_range(4));
		else
			c.safety_flag = FLAG_W'($urandom);
		return c;
	endfunction

	function automatic int random_step();
		case ($urandom_range(5))
			0: return 0;
			1: return 32767;
			2: return $urandom_range(32767);
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	// reset values of the registers, no writes
	task automatic test_reset_config();
		issue_tick(mk_tick(32767, -32768, 1'b1, FLAG_NORMAL));
		issue_tick(mk_tick(-32768, 32767, 1'b0, 255));
		issue_tick(mk_tick(1000, -1000, 1'b1, FLAG_SLOW));
		issue_tick(mk_tick(1000, -1000, 1'b1, FLAG_STOP));
		settle();
	endtask

	task automatic test_flag_codes();
		set_config(256, 32767, 32767, 30);
		issue_tick(mk_tick(-32768, 32767, 1'b1, FLAG_RED));
		issue_tick(mk_tick(-32768, 32767, 1'b1, FLAG_SLOW));
		issue_tick(mk_tick(-32768, 32767, 1'b1, FLAG_PED));
		issue_tick(mk_tick(-32768, 32767, 1'b1, FLAG_STOP));
		issue_tick(mk_tick(-32768, 32767, 1'b1, 5));
		issue_tick(mk_tick(32767, -32768, 1'b1, 255));
		issue_tick(mk_tick(32767, -32768, 1'b1, FLAG_NORMAL));
		settle();
	endtask

	// ratio above one saturates, negative products round towards minus infinity
	task automatic test_slow_scaling();
		set_config(511, 32767, 32767, 30);
		issue_tick(mk_tick(32767, -32768, 1'b1, FLAG_SLOW));
		issue_tick(mk_tick(-1, 1, 1'b0, FLAG_NORMAL));
		issue_tick(mk_tick(-300, 300, 1'b0, FLAG_NORMAL));
		settle();
		set_config(0, 32767, 32767, 30);
		issue_tick(mk_tick(12345, -12345, 1'b1, FLAG_SLOW));
		settle();
	endtask

	task automatic test_timeout();
		set_config(102, 17, 34, 0);
		issue_tick(mk_tick(1000, -1000, 1'b1, FLAG_STOP));
		issue_tick(mk_tick(1000, -1000, 1'b0, FLAG_STOP));
		issue_tick(mk_tick(-1000, 1000, 1'b0, FLAG_NORMAL));
		settle();
	endtask

	task automatic test_zero_step();
		set_config(102, 0, 0, 30);
		issue_tick(mk_tick(5000, -5000, 1'b1, FLAG_NORMAL));
		issue_tick(mk_tick(-32768, 32767, 1'b1, FLAG_STOP));
		issue_tick(random_tick(50));
		settle();
	endtask

	// the longest timeout keeps the stop flag in force, a short one then drops it
	task automatic test_long_timeout();
		set_config(256, 200, 300, 65535);
		issue_tick(mk_tick(3000, -3000, 1'b1, FLAG_STOP));
		repeat (40)
			issue_tick(random_tick(0));
		settle();
		set_config(256, 200, 300, 30);
		repeat (20)
			issue_tick(random_tick(0));
		settle();
	endtask

	task automatic test_random_ticks();
		int ratio;
		int tmo;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_config(102, 17, 34, 30);
				1: set_config(256, 32767, 32767, 65535);
				2: set_config(0, 0, 0, 0);
				default: begin
					ratio = ($urandom_range(3) == 0) ? $urandom_range(257, 511)
						: $urandom_range(256);
					tmo = ($urandom_range(7) == 0) ? $urandom_range(65535)
						: $urandom_range(60);
					set_config(ratio, random_step(), random_step(), tmo);
				end
			endcase
			steady = (phase == 3);
			repeat (240)
				issue_tick(random_tick(phase == 2 ? 30 : 8));
			settle();
			steady = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.nav_linear = '0;
		cmd_ch.nav_angular = '0;
		cmd_ch.flag_new = 1'b0;
		cmd_ch.safety_flag = '0;
		steady = 1'b0;
		ratio_q8 = SLOW_GAIN_RST;
		lin_step = LINEAR_STEP_RST;
		ang_step = ANGULAR_STEP_RST;
		flag_timeout = TIMEOUT_RST;
		held_flag = FLAG_NORMAL;
		ticks_idle = '0;
		lin_now = '0;
		ang_now = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_config();
		test_flag_codes();
		test_slow_scaling();
		test_timeout();
		test_zero_step();
		test_long_timeout();
		test_random_ticks();

		settle();
		repeat (8) @(posedge clk);
		n_mismatch += expected_vel_q.size();
		$display("%0d ticks over %0d register settings, %0d results checked",
			n_ticks, n_settings, n_checked);
		$display("flag codes, slow-mode saturation, short and long timeouts, zero step covered");
		if (n_mismatch == 0 && n_unexpected == 0)
			$display("[mode_gated_velocity_slew_limiter_core] OK");
		else
			$display("[mode_gated_velocity_slew_limiter_core] ERROR");
		$finish;
	end

endmodule
